// ===== hdl/qse_pkg.sv =====
`timescale 1ns / 1ps

package qse_pkg;

    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;

    // Operation codes carried in the func field of a request.
    localparam logic [FUNC_W-1:0] FN_ENQ   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_DEQ   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_LISTQ = 3'd2;
    localparam logic [FUNC_W-1:0] FN_COPY  = 3'd3;
    localparam logic [FUNC_W-1:0] FN_LISTS = 3'd4;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef logic signed [DATA_W-1:0] t_word;
    typedef logic [FUNC_W-1:0]        t_func;
    typedef logic [STAT_W-1:0]        t_status;

    typedef struct packed {
        t_word   data;
        t_status status;
        logic    last;
    } t_result;

endpackage

// ===== hdl/qse_if.sv =====
`timescale 1ns / 1ps

interface qse_in_if import qse_pkg::*; ();
    logic  valid;
    logic  ready;
    t_func func;
    t_word data_in;

    modport source (output valid, output func, output data_in, input ready);
    modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface qse_out_if import qse_pkg::*; ();
    logic    valid;
    logic    ready;
    t_word   data_out;
    t_status status;
    logic    last;

    modport source (output valid, output data_out, output status, output last, input ready);
    modport sink   (input valid, input data_out, input status, input last, output ready);
endinterface

// ===== hdl/queue_and_stack_engine.sv =====
`timescale 1ns / 1ps

// Queue and stack engine: a bounded FIFO queue and a LIFO stack of 32-bit words.
// Requests arrive on i_req (func, data_in) with a valid/ready handshake; results
// leave on o_rsp (data_out, status, last). Every request but an unused func code
// gives one or more results, and the final one carries last.
// The engine takes one request at a time: i_req.ready is high only while it is idle.
// Enqueue, dequeue and any empty result: the result is held in r_pend, then loaded
// into the output register, and the engine is idle again once it is loaded.
// Listing the queue or stack: each element is read from memory, then loaded into the
// output register, before the next element is read. Copying the queue to the stack
// moves each element by a read from the queue memory and then a write to the stack
// memory, and then gives its single result.
// A stalled receiver holds the engine: results wait in the output register, and
// the emit and list states do not advance until that register frees up.
// Reset (synchronous, active low) empties both the queue and the stack; the
// memory contents are not cleared and are never read before they are written.
module queue_and_stack_engine import qse_pkg::*; #(
    parameter int DEPTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    qse_in_if.sink    i_req,
    qse_out_if.source o_rsp
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_CNT  = CW'(1);
    localparam logic [AW-1:0] LAST_ADR = AW'(DEPTH - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EMIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_LIST = 3'd3;
    localparam logic [2:0] S_CPRD = 3'd4;
    localparam logic [2:0] S_CPWR = 3'd5;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] a);
        return (a == LAST_ADR) ? '0 : a + AW'(1);
    endfunction

    logic [2:0]    r_state;
    logic [AW-1:0] r_q_head;
    logic [AW-1:0] r_q_tail;
    logic [CW-1:0] r_q_count;
    logic [CW-1:0] r_s_count;
    logic [CW-1:0] r_left;
    logic          r_src_stack;
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_waddr;
    t_result       r_pend;

    logic          w_accept;
    logic          w_q_full;
    logic          w_enq_ok;
    logic          w_free;
    logic          w_load;
    logic [AW-1:0] w_addr_step;
    t_word         w_q_rdata;
    t_word         w_s_rdata;
    t_word         w_rdata;
    t_result       w_result;
    logic          w_q_re;
    logic          w_s_re;
    logic          w_s_we;

    assign i_req.ready = (r_state == S_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_q_full    = (r_q_count == FULL_CNT);
    assign w_enq_ok    = w_accept && (i_req.func == FN_ENQ) && !w_q_full;

    // The walk address moves up through the queue ring or down through the stack.
    assign w_addr_step = r_src_stack ? (r_addr - AW'(1)) : wrap_inc(r_addr);

    assign w_q_re = ((r_state == S_RD) && !r_src_stack) || (r_state == S_CPRD);
    assign w_s_re = (r_state == S_RD) && r_src_stack;
    assign w_s_we = (r_state == S_CPWR);

    qse_ram #(.DEPTH(DEPTH)) u_q_ram (
        .i_clk   (i_clk),
        .i_we    (w_enq_ok),
        .i_waddr (r_q_tail),
        .i_wdata (i_req.data_in),
        .i_re    (w_q_re),
        .i_raddr (r_addr),
        .o_rdata (w_q_rdata)
    );

    qse_ram #(.DEPTH(DEPTH)) u_s_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (r_waddr),
        .i_wdata (w_q_rdata),
        .i_re    (w_s_re),
        .i_raddr (r_addr),
        .o_rdata (w_s_rdata)
    );

    assign w_rdata = r_src_stack ? w_s_rdata : w_q_rdata;
    assign w_load  = w_free && ((r_state == S_EMIT) || (r_state == S_LIST));

    always_comb begin
        if (r_state == S_EMIT) begin
            w_result = r_pend;
        end else begin
            w_result.data   = w_rdata;
            w_result.status = ST_OK;
            w_result.last   = (r_left == ONE_CNT);
        end
    end

    qse_out_reg u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_load),
        .i_result (w_result),
        .o_free   (w_free),
        .o_rsp    (o_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_q_head    <= '0;
            r_q_tail    <= '0;
            r_q_count   <= '0;
            r_s_count   <= '0;
            r_left      <= '0;
            r_src_stack <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pend.data <= '0;
                        r_pend.last <= 1'b1;
                        unique case (i_req.func)
                            FN_ENQ: begin
                                if (w_q_full) begin
                                    r_pend.status <= ST_FULL;
                                end else begin
                                    r_pend.status <= ST_OK;
                                    r_q_tail      <= wrap_inc(r_q_tail);
                                    r_q_count     <= r_q_count + ONE_CNT;
                                end
                                r_state <= S_EMIT;
                            end
                            FN_DEQ: begin
                                if (r_q_count == '0) begin
                                    r_pend.status <= ST_EMPTY;
                                end else begin
                                    r_pend.status <= ST_OK;
                                    r_q_head      <= wrap_inc(r_q_head);
                                    r_q_count     <= r_q_count - ONE_CNT;
                                end
                                r_state <= S_EMIT;
                            end
                            FN_LISTQ: begin
                                r_pend.status <= ST_EMPTY;
                                r_src_stack   <= 1'b0;
                                r_addr        <= r_q_head;
                                r_left        <= r_q_count;
                                r_state       <= (r_q_count == '0) ? S_EMIT : S_RD;
                            end
                            FN_COPY: begin
                                // The head lands on the highest slot, so the walk
                                // writes the stack from the top down.
                                r_pend.status <= ST_OK;
                                r_s_count     <= r_q_count;
                                r_src_stack   <= 1'b0;
                                r_addr        <= r_q_head;
                                r_waddr       <= AW'(r_q_count - ONE_CNT);
                                r_left        <= r_q_count;
                                r_state       <= (r_q_count == '0) ? S_EMIT : S_CPRD;
                            end
                            FN_LISTS: begin
                                r_pend.status <= ST_EMPTY;
                                r_src_stack   <= 1'b1;
                                r_addr        <= AW'(r_s_count - ONE_CNT);
                                r_left        <= r_s_count;
                                r_state       <= (r_s_count == '0) ? S_EMIT : S_RD;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_RD: begin
                    r_state <= S_LIST;
                end
                S_LIST: begin
                    if (w_free) begin
                        if (r_left == ONE_CNT) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_addr  <= w_addr_step;
                            r_left  <= r_left - ONE_CNT;
                            r_state <= S_RD;
                        end
                    end
                end
                S_CPRD: begin
                    r_state <= S_CPWR;
                end
                S_CPWR: begin
                    r_addr  <= w_addr_step;
                    r_waddr <= r_waddr - AW'(1);
                    r_left  <= r_left - ONE_CNT;
                    r_state <= (r_left == ONE_CNT) ? S_EMIT : S_CPRD;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_count <= FULL_CNT) && (r_s_count <= FULL_CNT))
        else $error("queue or stack count exceeds the depth");

    a_ring_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_q_count == '0) || (r_q_count == FULL_CNT)) |-> (r_q_tail == r_q_head))
        else $error("queue head and tail disagree with the count");

    a_walk_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_RD) || (r_state == S_LIST) || (r_state == S_CPRD)
            || (r_state == S_CPWR)) |-> (r_left != '0))
        else $error("element walk running with nothing left");

    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_enq_ok |=> (r_q_count == $past(r_q_count) + ONE_CNT))
        else $error("stored enqueue did not grow the queue by one");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.ready) |=> (o_rsp.valid && $stable(o_rsp.data_out)
            && $stable(o_rsp.status) && $stable(o_rsp.last)))
        else $error("held result was overwritten");

endmodule

// ===== hdl/qse_ram.sv =====
`timescale 1ns / 1ps

module qse_ram import qse_pkg::*; #(
    parameter int DEPTH = 32,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_word         i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_word         o_rdata
);

    t_word r_mem [DEPTH];
    t_word r_rdata;

    // Read data holds until the next read, so the sequencer may wait on it.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/qse_out_reg.sv =====
`timescale 1ns / 1ps

module qse_out_reg import qse_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_result    i_result,
    output logic       o_free,
    qse_out_if.source  o_rsp
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_rsp.valid    = r_valid;
    assign o_rsp.data_out = r_result.data;
    assign o_rsp.status   = r_result.status;
    assign o_rsp.last     = r_result.last;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import qse_pkg::*;

    localparam int DEPTH     = 32;
    localparam int LONG_HOLD = 300;

    logic i_clk = 1'b0;
    logic i_rst_n;

    qse_in_if  req_if ();
    qse_out_if rsp_if ();

    queue_and_stack_engine #(.DEPTH(DEPTH)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always #5 i_clk = ~i_clk;

    // Shadow copy of the engine state.
    t_word q_words [DEPTH];
    int    q_head;
    int    q_tail;
    int    q_count;
    t_word s_words [DEPTH];
    int    s_count;

    // Results still owed by the engine, oldest first.
    t_result rsp_due [$];

    int mismatch_count = 0;
    int hold_requests  = 0;
    int burst_left     = 0;
    bit req_held       = 1'b0;

    function automatic void owe(t_word d, t_status s, logic l);
        t_result r;
        r.data   = d;
        r.status = s;
        r.last   = l;
        rsp_due.push_back(r);
    endfunction

    function automatic void clear_engine_state();
        for (int i = 0; i < DEPTH; i++) begin
            q_words[i] = '0;
            s_words[i] = '0;
        end
        q_head  = 0;
        q_tail  = 0;
        q_count = 0;
        s_count = 0;
    endfunction

    // Applies one request to the shadow state and queues the results it causes.
    function automatic void step_queue_stack(t_func f, t_word d);
        int idx;
        case (f)
            FN_ENQ: begin
                if (q_count == DEPTH) begin
                    owe('0, ST_FULL, 1'b1);
                end else begin
                    q_words[q_tail] = d;
                    q_tail = (q_tail + 1) % DEPTH;
                    q_count++;
                    owe('0, ST_OK, 1'b1);
                end
            end
            FN_DEQ: begin
                if (q_count == 0) begin
                    owe('0, ST_EMPTY, 1'b1);
                end else begin
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                    owe('0, ST_OK, 1'b1);
                end
            end
            FN_LISTQ: begin
                if (q_count == 0) begin
                    owe('0, ST_EMPTY, 1'b1);
                end else begin
                    idx = q_head;
                    for (int i = 0; i < q_count; i++) begin
                        owe(q_words[idx], ST_OK, i + 1 == q_count);
                        idx = (idx + 1) % DEPTH;
                    end
                end
            end
            FN_COPY: begin
                // The head of the queue ends up on top of the stack.
                idx = q_head;
                s_count = q_count;
                for (int i = 0; i < q_count; i++) begin
                    s_words[q_count - 1 - i] = q_words[idx];
                    idx = (idx + 1) % DEPTH;
                end
                owe('0, ST_OK, 1'b1);
            end
            FN_LISTS: begin
                if (s_count == 0) begin
                    owe('0, ST_EMPTY, 1'b1);
                end else begin
                    for (int i = 0; i < s_count; i++)
                        owe(s_words[s_count - 1 - i], ST_OK, i + 1 == s_count);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic void flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("[%0t] %s", $realtime, what);
    endfunction

    function automatic t_word rand_word();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge i_clk) begin : rsp_check
        t_result want;
        if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (rsp_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result: data %0d status %0d last %0b",
                    rsp_if.data_out, rsp_if.status, rsp_if.last));
            end else begin
                want = rsp_due.pop_front();
                if (rsp_if.data_out !== want.data || rsp_if.status !== want.status ||
                        rsp_if.last !== want.last)
                    flag_mismatch($sformatf(
                        "mismatch: exp data %0d got %0d, status %0d got %0d, last %0b got %0b",
                        want.data, rsp_if.data_out, want.status, rsp_if.status,
                        want.last, rsp_if.last));
            end
        end
    end

    // Receiver: switches between stall patterns and serves long hold-off requests.
    initial begin : rsp_pacer
        int stall_left;
        int mode;
        int mode_left;
        int hold_served;
        stall_left  = 0;
        mode        = 0;
        mode_left   = 0;
        hold_served = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 2);
                mode_left = $urandom_range(64, 256);
            end else begin
                mode_left--;
            end
            if (stall_left > 0) begin
                rsp_if.ready <= 1'b0;
                stall_left--;
            end else begin
                case (mode)
                    0: rsp_if.ready <= 1'b1;
                    1: rsp_if.ready <= $urandom_range(0, 1);
                    default: begin
                        if ($urandom_range(0, 15) == 0) begin
                            stall_left = $urandom_range(1, 12);
                            rsp_if.ready <= 1'b0;
                        end else begin
                            rsp_if.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    task automatic release_req();
        if (req_held) begin
            req_if.valid <= 1'b0;
            req_held = 1'b0;
        end
    endtask

    // Ends a burst now and then with a gap of random length.
    task automatic pace();
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            release_req();
            repeat ($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6)) @(posedge i_clk);
            burst_left = $urandom_range(0, 12);
        end
    endtask

    task automatic send_req(t_func f, t_word d);
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.data_in <= d;
        req_held = 1'b1;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        step_queue_stack(f, d);
        pace();
    endtask

    // Always waits for a clock edge before it checks, so the next request starts in a later step.
    task automatic wait_drained();
        release_req();
        do @(posedge i_clk); while (rsp_due.size() != 0);
    endtask

    task automatic test_empty_cases();
        send_req(FN_LISTQ, rand_word());
        send_req(FN_LISTS, rand_word());
        send_req(FN_DEQ, rand_word());
        send_req(FN_COPY, rand_word());
        send_req(FN_LISTS, rand_word());
        send_req(t_func'(5), rand_word());
        send_req(t_func'(6), rand_word());
        send_req(t_func'(7), rand_word());
    endtask

    task automatic test_extremes();
        send_req(FN_ENQ, 32'h8000_0000);
        send_req(FN_ENQ, 32'h7fff_ffff);
        send_req(FN_ENQ, 32'h0000_0000);
        send_req(FN_ENQ, 32'hffff_ffff);
        send_req(FN_ENQ, 32'h5555_5555);
        send_req(FN_ENQ, 32'haaaa_aaaa);
        send_req(FN_LISTQ, 32'hffff_ffff);
        send_req(FN_COPY, 32'h8000_0000);
        send_req(FN_LISTS, 32'h7fff_ffff);
        send_req(FN_DEQ, 32'h5555_5555);
        send_req(FN_LISTQ, 32'h0000_0000);
        send_req(FN_LISTS, 32'haaaa_aaaa);
    endtask

    task automatic test_fill_and_drain();
        while (q_count < DEPTH)
            send_req(FN_ENQ, rand_word());
        send_req(FN_ENQ, rand_word());
        send_req(FN_ENQ, rand_word());
        send_req(FN_LISTQ, rand_word());
        send_req(FN_COPY, rand_word());
        send_req(FN_LISTS, rand_word());
        repeat (DEPTH + 1)
            send_req(FN_DEQ, rand_word());
        send_req(FN_LISTS, rand_word());
        // Copying an empty queue must leave the stack empty.
        send_req(FN_COPY, rand_word());
        send_req(FN_LISTS, rand_word());
        send_req(FN_LISTQ, rand_word());
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_requests <= hold_requests + 1;
        repeat (6)
            send_req(FN_ENQ, rand_word());
        send_req(FN_LISTQ, rand_word());
        send_req(FN_COPY, rand_word());
        send_req(FN_LISTS, rand_word());
        wait_drained();
        send_req(FN_DEQ, rand_word());
        send_req(FN_LISTQ, rand_word());
    endtask

    task automatic test_random_mix(int n_items, int enq_weight);
        int   sent;
        int   pick;
        t_func f;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < enq_weight)
                f = FN_ENQ;
            else if (pick < 80)
                f = FN_DEQ;
            else if (pick < 87)
                f = FN_LISTQ;
            else if (pick < 93)
                f = FN_COPY;
            else if (pick < 97)
                f = FN_LISTS;
            else
                f = t_func'($urandom_range(5, 7));
            send_req(f, rand_word());
            if (f <= FN_LISTS)
                sent++;
            if ($urandom_range(0, 40) == 0)
                wait_drained();
        end
    endtask

    initial begin
        req_if.valid   <= 1'b0;
        req_if.func    <= FN_ENQ;
        req_if.data_in <= '0;
        i_rst_n        <= 1'b0;
        clear_engine_state();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_cases();
        test_extremes();
        test_fill_and_drain();
        test_backpressure();
        test_random_mix(25, 60);
        test_random_mix(25, 35);

        wait_drained();
        repeat (4 * DEPTH + 8) @(posedge i_clk);
        if (mismatch_count == 0 && rsp_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #5ms;
        $display("status: fail");
        $finish;
    end

endmodule
